FILE: sv/mrms_pkg.sv
// ---------------------------------------------------------------------------
// mrms_pkg
// Shared types, constants and tables for the material rule match/select block.
// ---------------------------------------------------------------------------
package mrms_pkg;

   // Capacity of the rule table
   localparam int MAX_RULES = 16;
   localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W     = $clog2(MAX_RULES + 1);

   // Field widths
   localparam int HASH_W  = 64;
   localparam int MASK_W  = 8;
   localparam int DIM_W   = 16;
   localparam int TAG_W   = 16;
   localparam int PROF_W  = 2;
   localparam int VAL_W   = 17;
   localparam int FLAG_W  = 2;
   localparam int SLOT_W  = 8;
   localparam int SSEL_W  = 3;
   localparam int Q15_W   = 16;

   // Packed store words
   localparam int MATCH_W = MASK_W + 2 * DIM_W;                          // 40
   localparam int VALUE_W = TAG_W + PROF_W + 2 * VAL_W + FLAG_W;         // 54

   // Q1.15 limits
   localparam logic signed [VAL_W-1:0] Q15_ONE       = 17'sd32768;
   localparam logic signed [VAL_W-1:0] Q15_ZERO      = 17'sd0;
   localparam logic signed [VAL_W-1:0] ROUGH_MIN     = 17'sd655;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_TEXTURE = 2'd2,
      ACT_NONE    = 2'd3
   } mrms_action_type;

   // Profile tables: water, metal, polished, custom
   localparam logic [Q15_W-1:0] DEFAULT_REFL [4]  = '{16'd25559, 16'd28836, 16'd19005, 16'd21299};
   localparam logic [Q15_W-1:0] DEFAULT_ROUGH [4] = '{16'd3277, 16'd7209, 16'd10486, 16'd11469};
   localparam logic [Q15_W-1:0] CLASS_VALUE [4]   = '{16'd20480, 16'd24576, 16'd28672, 16'd32768};

   // Controller to datapath
   typedef struct packed {
      logic capture;   // take the request fields (clear, append or texture)
      logic scan;      // walk the rule table, compare and select
      logic rd_best;   // read the selected rule entry
      logic emit;      // register the result and clear the selection
   } mrms_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done; // hit found or table exhausted
      logic tex_last;  // captured texture closes its list
   } mrms_status_type;

endpackage

FILE: sv/mrms_ctrl.sv
// ---------------------------------------------------------------------------
// mrms_ctrl
// Sequencer: accepts items, runs the rule scan, and steps out a result.
// ---------------------------------------------------------------------------
module mrms_ctrl
   import mrms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_action,
   input  mrms_status_type status,
   output mrms_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ_BEST,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
            if (start && (req_action == ACT_TEXTURE)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = status.tex_last ? ST_READ_BEST : ST_IDLE;
            end
         end
         ST_READ_BEST: begin
            cmd.rd_best = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

`ifndef SYNTHESIS
   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy out of step with state");

   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ_BEST) |=> (state_ff == ST_EMIT))
      else $error("result read not followed by emit");

   a_emit_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |=> (state_ff == ST_IDLE))
      else $error("emit did not return to idle");
`endif

endmodule

FILE: sv/mrms_dp.sv
// ---------------------------------------------------------------------------
// mrms_dp
// Rule stores, scan pipeline, selection registers and result formatting.
// ---------------------------------------------------------------------------
module mrms_dp
   import mrms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mrms_cmd_type              cmd,
   output mrms_status_type           status,
   input  logic [1:0]                req_action,
   input  logic [HASH_W-1:0]         req_content_hash,
   input  logic [MASK_W-1:0]         req_slot_mask,
   input  logic [DIM_W-1:0]          req_tex_width,
   input  logic [DIM_W-1:0]          req_tex_height,
   input  logic [TAG_W-1:0]          req_rule_tag,
   input  logic [PROF_W-1:0]         req_profile,
   input  logic signed [VAL_W-1:0]   req_reflectivity_in,
   input  logic signed [VAL_W-1:0]   req_roughness_in,
   input  logic [FLAG_W-1:0]         req_finite_flags,
   input  logic [SLOT_W-1:0]         req_slot,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [TAG_W-1:0]          rsp_rule_id_out,
   output logic [HASH_W-1:0]         rsp_texture_hash_out,
   output logic [SSEL_W-1:0]         rsp_slot_out,
   output logic [PROF_W-1:0]         rsp_profile_out,
   output logic [Q15_W-1:0]          rsp_reflectivity_out,
   output logic [Q15_W-1:0]          rsp_roughness_out,
   output logic [Q15_W-1:0]          rsp_material_class
);

   // rule stores
   logic [HASH_W-1:0]  hash_mem  [MAX_RULES];
   logic [MATCH_W-1:0] match_mem [MAX_RULES];
   logic [VALUE_W-1:0] value_mem [MAX_RULES];

   logic [HASH_W-1:0]  hash_rd_ff;
   logic [MATCH_W-1:0] match_rd_ff;
   logic [VALUE_W-1:0] value_rd_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [CNT_W-1:0]   rule_count_ff;
   logic               table_full;
   logic               do_clear, do_append, do_texture;

   // captured texture
   logic [HASH_W-1:0]  tex_hash_ff;
   logic [DIM_W-1:0]   tex_w_ff, tex_h_ff;
   logic [SLOT_W-1:0]  tex_slot_ff;
   logic               tex_last_ff;

   // scan pipeline
   logic [CNT_W-1:0]   scan_idx_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               cmp_valid_ff;
   logic               issue;
   logic               hit;

   // selection
   logic               best_valid_ff;
   logic [SSEL_W-1:0]  best_slot_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [HASH_W-1:0]  best_hash_ff;
   logic               take;

   // result formatting
   logic [PROF_W-1:0]        v_prof;
   logic [FLAG_W-1:0]        v_flags;
   logic signed [VAL_W-1:0]  v_refl, v_rough;
   logic [Q15_W-1:0]         refl_fmt, rough_fmt;
   logic [MASK_W-1:0]        r_mask;
   logic [DIM_W-1:0]         r_w, r_h;

   logic                     rsp_valid_ff, rsp_found_ff;
   logic [TAG_W-1:0]         rsp_tag_ff;
   logic [HASH_W-1:0]        rsp_hash_ff;
   logic [SSEL_W-1:0]        rsp_slot_ff;
   logic [PROF_W-1:0]        rsp_prof_ff;
   logic [Q15_W-1:0]         rsp_refl_ff, rsp_rough_ff, rsp_class_ff;

   assign do_clear   = cmd.capture && (req_action == ACT_CLEAR);
   assign do_append  = cmd.capture && (req_action == ACT_APPEND);
   assign do_texture = cmd.capture && (req_action == ACT_TEXTURE);
   assign table_full = (rule_count_ff >= CNT_W'(MAX_RULES));

   // stores: one write port, one registered read port
   assign rd_addr = cmd.rd_best ? best_idx_ff : scan_idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (do_append && !table_full) begin
         hash_mem[rule_count_ff[IDX_W-1:0]]  <= req_content_hash;
         match_mem[rule_count_ff[IDX_W-1:0]] <= {req_tex_height, req_tex_width, req_slot_mask};
         value_mem[rule_count_ff[IDX_W-1:0]] <= {req_finite_flags, req_roughness_in,
                                                 req_reflectivity_in, req_profile, req_rule_tag};
      end
      hash_rd_ff  <= hash_mem[rd_addr];
      match_rd_ff <= match_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   // compare stage
   assign r_mask = match_rd_ff[MASK_W-1:0];
   assign r_w    = match_rd_ff[MASK_W +: DIM_W];
   assign r_h    = match_rd_ff[MASK_W+DIM_W +: DIM_W];

   assign issue = cmd.scan && (scan_idx_ff < rule_count_ff);
   assign hit   = cmd.scan && cmp_valid_ff
                  && (hash_rd_ff != '0) && (hash_rd_ff == tex_hash_ff)
                  && (tex_slot_ff < SLOT_W'(8)) && r_mask[tex_slot_ff[SSEL_W-1:0]]
                  && ((r_w == '0) || (r_w == tex_w_ff))
                  && ((r_h == '0) || (r_h == tex_h_ff));
   assign take  = hit && (!best_valid_ff || (tex_slot_ff[SSEL_W-1:0] < best_slot_ff));

   assign status.scan_done = hit || (!issue && !cmp_valid_ff);
   assign status.tex_last  = tex_last_ff;

   always_ff @(posedge clock) begin
      if (do_texture) begin
         tex_hash_ff <= req_content_hash;
         tex_w_ff    <= req_tex_width;
         tex_h_ff    <= req_tex_height;
         tex_slot_ff <= req_slot;
         tex_last_ff <= req_last;
      end
      if (issue) begin
         cmp_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         best_slot_ff  <= '0;
         best_idx_ff   <= '0;
         best_hash_ff  <= '0;
      end else begin
         if (do_clear) begin
            rule_count_ff <= '0;
         end else if (do_append && !table_full) begin
            rule_count_ff <= rule_count_ff + CNT_W'(1);
         end

         if (do_texture) begin
            scan_idx_ff  <= '0;
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            cmp_valid_ff <= issue;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
         end else begin
            cmp_valid_ff <= 1'b0;
         end

         if (cmd.emit) begin
            best_valid_ff <= 1'b0;
            best_slot_ff  <= '0;
            best_idx_ff   <= '0;
            best_hash_ff  <= '0;
         end else if (take) begin
            best_valid_ff <= 1'b1;
            best_slot_ff  <= tex_slot_ff[SSEL_W-1:0];
            best_idx_ff   <= cmp_idx_ff;
            best_hash_ff  <= tex_hash_ff;
         end
      end
   end

   // result fields from the selected entry
   assign v_prof  = value_rd_ff[TAG_W +: PROF_W];
   assign v_refl  = value_rd_ff[TAG_W+PROF_W +: VAL_W];
   assign v_rough = value_rd_ff[TAG_W+PROF_W+VAL_W +: VAL_W];
   assign v_flags = value_rd_ff[TAG_W+PROF_W+2*VAL_W +: FLAG_W];

   always_comb begin
      if (!v_flags[0]) begin
         refl_fmt = DEFAULT_REFL[v_prof];
      end else if (v_refl < Q15_ZERO) begin
         refl_fmt = '0;
      end else if (v_refl > Q15_ONE) begin
         refl_fmt = Q15_ONE[Q15_W-1:0];
      end else begin
         refl_fmt = v_refl[Q15_W-1:0];
      end
      if (!v_flags[1]) begin
         rough_fmt = DEFAULT_ROUGH[v_prof];
      end else if (v_rough < ROUGH_MIN) begin
         rough_fmt = ROUGH_MIN[Q15_W-1:0];
      end else if (v_rough > Q15_ONE) begin
         rough_fmt = Q15_ONE[Q15_W-1:0];
      end else begin
         rough_fmt = v_rough[Q15_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_found_ff <= best_valid_ff;
         if (best_valid_ff) begin
            rsp_tag_ff   <= value_rd_ff[TAG_W-1:0];
            rsp_hash_ff  <= best_hash_ff;
            rsp_slot_ff  <= best_slot_ff;
            rsp_prof_ff  <= v_prof;
            rsp_refl_ff  <= refl_fmt;
            rsp_rough_ff <= rough_fmt;
            rsp_class_ff <= CLASS_VALUE[v_prof];
         end else begin
            rsp_tag_ff   <= '0;
            rsp_hash_ff  <= '0;
            rsp_slot_ff  <= '0;
            rsp_prof_ff  <= '0;
            rsp_refl_ff  <= '0;
            rsp_rough_ff <= '0;
            rsp_class_ff <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_rule_id_out      = rsp_tag_ff;
   assign rsp_texture_hash_out = rsp_hash_ff;
   assign rsp_slot_out         = rsp_slot_ff;
   assign rsp_profile_out      = rsp_prof_ff;
   assign rsp_reflectivity_out = rsp_refl_ff;
   assign rsp_roughness_out    = rsp_rough_ff;
   assign rsp_material_class   = rsp_class_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count beyond capacity");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_found_rough_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_rough_ff >= ROUGH_MIN[Q15_W-1:0]))
      else $error("roughness below floor on a found result");

   a_selection_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !best_valid_ff)
      else $error("selection not cleared after result");
`endif

endmodule

FILE: sv/material_rule_match_select.sv
// ---------------------------------------------------------------------------
// material_rule_match_select
// Material rule table with first-match lookup and lowest-slot texture pick.
// ---------------------------------------------------------------------------
//
//  channel  | handshake          | direction | carries
//  ---------+--------------------+-----------+-------------------------------
//  request  | start / busy       | in        | clear, append rule, texture
//  response | rsp_valid (strobe) | out       | selected rule and material
//
// Clear and append items are taken while busy stays low.
// A texture walks the rule table through a one-read-per-cycle store port
// with a registered read and stops at the first hit or at the table end.
// A last texture then reads the selected entry and formats the result;
// the result strobe follows in the next cycle.
// Reset: synchronous, clears counts, selection and the sequencer; the rule
// stores hold whatever they held. The receiver cannot stall: each result
// is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module material_rule_match_select
   import mrms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic [HASH_W-1:0]         req_content_hash,
   input  logic [MASK_W-1:0]         req_slot_mask,
   input  logic [DIM_W-1:0]          req_tex_width,
   input  logic [DIM_W-1:0]          req_tex_height,
   input  logic [TAG_W-1:0]          req_rule_tag,
   input  logic [PROF_W-1:0]         req_profile,
   input  logic signed [VAL_W-1:0]   req_reflectivity_in,
   input  logic signed [VAL_W-1:0]   req_roughness_in,
   input  logic [FLAG_W-1:0]         req_finite_flags,
   input  logic [SLOT_W-1:0]         req_slot,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [TAG_W-1:0]          rsp_rule_id_out,
   output logic [HASH_W-1:0]         rsp_texture_hash_out,
   output logic [SSEL_W-1:0]         rsp_slot_out,
   output logic [PROF_W-1:0]         rsp_profile_out,
   output logic [Q15_W-1:0]          rsp_reflectivity_out,
   output logic [Q15_W-1:0]          rsp_roughness_out,
   output logic [Q15_W-1:0]          rsp_material_class
);

   mrms_cmd_type    cmd;
   mrms_status_type status;

   // sequencer: idle -> scan -> (read selected -> emit) -> idle
   mrms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // stores, compare stage, selection and output registers
   mrms_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_action           (req_action),
      .req_content_hash     (req_content_hash),
      .req_slot_mask        (req_slot_mask),
      .req_tex_width        (req_tex_width),
      .req_tex_height       (req_tex_height),
      .req_rule_tag         (req_rule_tag),
      .req_profile          (req_profile),
      .req_reflectivity_in  (req_reflectivity_in),
      .req_roughness_in     (req_roughness_in),
      .req_finite_flags     (req_finite_flags),
      .req_slot             (req_slot),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_found            (rsp_found),
      .rsp_rule_id_out      (rsp_rule_id_out),
      .rsp_texture_hash_out (rsp_texture_hash_out),
      .rsp_slot_out         (rsp_slot_out),
      .rsp_profile_out      (rsp_profile_out),
      .rsp_reflectivity_out (rsp_reflectivity_out),
      .rsp_roughness_out    (rsp_roughness_out),
      .rsp_material_class   (rsp_material_class)
   );

endmodule
